[rtl/ttv_pkg.sv]
// ttv_pkg: shared widths and the datapath command type for the tangent unit
// no dependencies
package ttv_pkg;
	localparam int POS_W = 24;
	localparam int TEX_W = 18;
	localparam int TAN_W = 16;
	localparam int RAW_W = 48;
	localparam int NRM_W = 24;
	localparam int SUM_W = 64;
	localparam int LEN_W = 32;
	localparam logic [14:0] TAN_ONE = 15'd16384;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DET,
		OP_RAW,
		OP_SQR,
		OP_DIV
	} op_t;
endpackage

[rtl/triangle_tangent_vector_unit.sv]
// triangle_tangent_vector_unit: per-triangle tangent, normalized, sent per corner
// uses ttv_pkg and ttv_divsqrt
//
//  channel | signals                               | dir
//  in      | in_valid in_ready pos_x/y/z tex_u/v   | input item
//  out     | out_valid out_ready tan_x/y/z corner  | result item
//          | last_of_run degenerate                |
//
// corners 0 and 1 are stored as they arrive; the third corner runs a sequencer
// over one shared multiplier and the serial sqrt/divide unit (32 sqrt steps,
// three 64-step divides) before the three results.
// reset clears the corner count and sequencer; held corners reset to zero.
// a stalled output holds the sequencer; input is not ready during a triangle.
module triangle_tangent_vector_unit import ttv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [TEX_W-1:0] tex_u,
	input  logic signed [TEX_W-1:0] tex_v,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [TAN_W-1:0] tan_x,
	output logic signed [TAN_W-1:0] tan_y,
	output logic signed [TAN_W-1:0] tan_z,
	output logic [1:0]              corner,
	output logic                    last_of_run,
	output logic                    degenerate
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DET0, ST_DET1, ST_RAW0, ST_RAW1, ST_SHIFT, ST_SQR,
		ST_SQRT, ST_WSQRT, ST_DIV, ST_WDIV, ST_EMIT
	} state_t;

	state_t state_q;
	logic [1:0] cnt_q;
	logic signed [POS_W-1:0] p0_q [3];
	logic signed [POS_W-1:0] p1_q [3];
	logic signed [TEX_W-1:0] t0_q [2];
	logic signed [TEX_W-1:0] t1_q [2];
	logic signed [POS_W:0]   e1_q [3];
	logic signed [POS_W:0]   e2_q [3];
	logic signed [TEX_W:0]   du1_q, dv1_q, du2_q, dv2_q;
	logic signed [RAW_W-1:0] acc_q, raw_q [3];
	logic signed [39:0]      det_q;
	logic [RAW_W-1:0]        m_q [3];
	logic [1:0]              idx_q;
	logic [SUM_W-1:0]        sum_q;
	logic [LEN_W-1:0]        len_q;
	logic signed [TAN_W-1:0] res_q [3];
	logic                    degen_q;
	logic [1:0]              corner_q;

	// shared multiplier, 25x25 signed
	logic signed [POS_W:0]   ma, mb;
	logic signed [2*POS_W+1:0] prod;
	assign prod = ma * mb;

	logic [RAW_W-1:0] mx, mnorm;
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
		mnorm = m_q[idx_q];
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_DET0: begin ma = 25'(du1_q); mb = 25'(dv2_q); end
			ST_DET1: begin ma = 25'(dv1_q); mb = 25'(du2_q); end
			ST_RAW0: begin ma = 25'(dv2_q); mb = e1_q[idx_q]; end
			ST_RAW1: begin ma = 25'(dv1_q); mb = e2_q[idx_q]; end
			ST_SQR:  begin
				ma = $signed({1'b0, mnorm[NRM_W-1:0]});
				mb = $signed({1'b0, mnorm[NRM_W-1:0]});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	logic            u_start, u_sqrt, u_busy;
	logic [SUM_W-1:0] u_num, u_res;
	assign u_start = (state_q == ST_SQRT) || (state_q == ST_DIV);
	assign u_sqrt  = (state_q == ST_SQRT);
	assign u_num   = u_sqrt ? {sum_q[SUM_W-13:0], 12'd0}
		: ({20'd0, mnorm[43:0]} << 20) + {33'd0, len_q[LEN_W-1:1]};

	ttv_divsqrt u_unit (
		.clk(clk), .arst_n(arst_n), .start(u_start), .is_sqrt(u_sqrt),
		.num(u_num), .den(len_q), .busy(u_busy), .res(u_res)
	);

	logic [14:0] qclamp;
	logic        neg;
	assign qclamp = (u_res > SUM_W'(TAN_ONE)) ? TAN_ONE : u_res[14:0];
	assign neg    = raw_q[idx_q][RAW_W-1] != det_q[39];

	assign in_ready    = state_q == ST_IDLE;
	assign out_valid   = state_q == ST_EMIT;
	assign tan_x       = res_q[0];
	assign tan_y       = res_q[1];
	assign tan_z       = res_q[2];
	assign corner      = corner_q;
	assign last_of_run = corner_q == 2'd2;
	assign degenerate  = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			corner_q <= '0;
			for (int i = 0; i < 3; i++) begin
				p0_q[i] <= '0;
				p1_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				t0_q[i] <= '0;
				t1_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					if (cnt_q == 2'd0) begin
						p0_q[0] <= pos_x; p0_q[1] <= pos_y; p0_q[2] <= pos_z;
						t0_q[0] <= tex_u; t0_q[1] <= tex_v;
						cnt_q <= 2'd1;
					end else if (cnt_q == 2'd1) begin
						p1_q[0] <= pos_x; p1_q[1] <= pos_y; p1_q[2] <= pos_z;
						t1_q[0] <= tex_u; t1_q[1] <= tex_v;
						cnt_q <= 2'd2;
					end else begin
						e1_q[0] <= 25'(p1_q[0]) - 25'(p0_q[0]);
						e1_q[1] <= 25'(p1_q[1]) - 25'(p0_q[1]);
						e1_q[2] <= 25'(p1_q[2]) - 25'(p0_q[2]);
						e2_q[0] <= 25'(pos_x) - 25'(p0_q[0]);
						e2_q[1] <= 25'(pos_y) - 25'(p0_q[1]);
						e2_q[2] <= 25'(pos_z) - 25'(p0_q[2]);
						du1_q <= 19'(t1_q[0]) - 19'(t0_q[0]);
						dv1_q <= 19'(t1_q[1]) - 19'(t0_q[1]);
						du2_q <= 19'(tex_u) - 19'(t0_q[0]);
						dv2_q <= 19'(tex_v) - 19'(t0_q[1]);
						cnt_q <= 2'd0;
						state_q <= ST_DET0;
					end
				end
				ST_DET0: begin
					det_q <= 40'(prod);
					state_q <= ST_DET1;
				end
				ST_DET1: begin
					det_q <= det_q - 40'(prod);
					idx_q <= '0;
					state_q <= ST_RAW0;
				end
				ST_RAW0: begin
					acc_q <= RAW_W'(prod);
					state_q <= ST_RAW1;
				end
				ST_RAW1: begin
					raw_q[idx_q] <= acc_q - RAW_W'(prod);
					m_q[idx_q] <= (acc_q - RAW_W'(prod)) < 0
						? RAW_W'(-(acc_q - RAW_W'(prod))) : RAW_W'(acc_q - RAW_W'(prod));
					if (idx_q == 2'd2) state_q <= ST_SHIFT;
					else begin idx_q <= idx_q + 2'd1; state_q <= ST_RAW0; end
				end
				ST_SHIFT: begin
					// one shift step a cycle until all magnitudes fit 24 bits
					if (det_q == 0 || mx == 0) begin
						degen_q <= 1'b1;
						for (int i = 0; i < 3; i++) res_q[i] <= '0;
						corner_q <= '0;
						state_q <= ST_EMIT;
					end else if (mx[RAW_W-1:NRM_W] != 0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else begin
						degen_q <= 1'b0;
						sum_q <= '0;
						idx_q <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					sum_q <= sum_q + SUM_W'(prod);
					if (idx_q == 2'd2) state_q <= ST_SQRT;
					else idx_q <= idx_q + 2'd1;
				end
				ST_SQRT: state_q <= ST_WSQRT;
				ST_WSQRT: if (!u_busy) begin
					len_q <= u_res[LEN_W-1:0];
					idx_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_WDIV;
				ST_WDIV: if (!u_busy) begin
					res_q[idx_q] <= neg ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
					if (idx_q == 2'd2) begin
						corner_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= ST_DIV;
					end
				end
				ST_EMIT: if (out_ready) begin
					if (corner_q == 2'd2) state_q <= ST_IDLE;
					corner_q <= corner_q + 2'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while results pending");
	a_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corner_q != 2'd3) else $error("bad corner");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tan_x == 0 && tan_y == 0 && tan_z == 0)
		else $error("degenerate with nonzero tangent");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("corner count overflow");
`endif
endmodule

[rtl/ttv_divsqrt.sv]
// ttv_divsqrt: shared bit-serial unit, integer square root or unsigned divide
// one result bit per cycle; uses ttv_pkg
module ttv_divsqrt import ttv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              is_sqrt,
	input  logic [SUM_W-1:0]  num,
	input  logic [LEN_W-1:0]  den,
	output logic              busy,
	output logic [SUM_W-1:0]  res
);
	logic [SUM_W-1:0] x_q, r_q, bit_q, q_q, rem_q;
	logic [LEN_W-1:0] d_q;
	logic [6:0]       cnt_q;
	logic             sq_q;
	logic [SUM_W:0]   trial;
	logic [SUM_W-1:0] rsh;

	assign rsh   = {rem_q[SUM_W-2:0], x_q[SUM_W-1]};
	assign trial = {1'b0, rsh} - {{(SUM_W+1-LEN_W){1'b0}}, d_q};
	assign res   = sq_q ? r_q : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
			sq_q  <= 1'b0;
		end else if (start) begin
			busy  <= 1'b1;
			sq_q  <= is_sqrt;
			x_q   <= num;
			d_q   <= den;
			r_q   <= '0;
			q_q   <= '0;
			rem_q <= '0;
			bit_q <= {2'b01, {(SUM_W-2){1'b0}}};
			cnt_q <= is_sqrt ? 7'd32 : 7'd64;
		end else if (busy) begin
			if (sq_q) begin
				if (x_q >= r_q + bit_q) begin
					x_q <= x_q - (r_q + bit_q);
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				x_q <= x_q << 1;
				if (!trial[SUM_W]) begin
					rem_q <= trial[SUM_W-1:0];
					q_q   <= {q_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					q_q   <= {q_q[SUM_W-2:0], 1'b0};
				end
			end
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				busy <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !start |-> cnt_q != 7'd0) else $error("count ran out while busy");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !start && cnt_q == 7'd1 |=> !busy) else $error("unit did not finish");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("start did not take");
`endif
endmodule
